FILE: hdl/nrp_pkg.sv
// nrp_pkg: shared constants, codes and types of the nested region profiler
// no dependencies; compiled first
package nrp_pkg;

    localparam int SLOTS_DEF     = 32;
    localparam int TIME_BITS_DEF = 32;
    localparam int PCT_W         = 15;
    localparam int SCALE_W       = 48;   // frame is narrowed to this before the share division

    localparam logic [PCT_W-1:0] FULL_PCT = 15'd25600;

    // request codes
    localparam logic [2:0] REQ_OPEN      = 3'd0;
    localparam logic [2:0] REQ_CLOSE     = 3'd1;
    localparam logic [2:0] REQ_REPORT    = 3'd2;
    localparam logic [2:0] REQ_RESET_ONE = 3'd3;
    localparam logic [2:0] REQ_RESET_ALL = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_ALREADY   = 3'd2;
    localparam logic [2:0] ST_NONE_OPEN = 3'd3;
    localparam logic [2:0] ST_DISABLED  = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ENTRY  = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_CHK,
        S_OPEN_UPD,
        S_RST_UPD,
        S_CL_RD,
        S_CL_SELF,
        S_CL_PAR,
        S_ALL_SCAN,
        S_ALL_UPD,
        S_RP_SCAN,
        S_RP_SELF,
        S_RP_SCALE,
        S_RP_DIV1,
        S_RP_MUL,
        S_RP_AVG,
        S_RP_DIV2,
        S_RP_UPD,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [2:0]       status;
        logic [15:0]      entry_key;
        logic [31:0]      frame_time;
        logic [31:0]      self_time;
        logic [31:0]      call_count;
        logic [5:0]       depth;
        logic [PCT_W-1:0] min_pct;
        logic [PCT_W-1:0] avg_pct;
        logic [PCT_W-1:0] max_pct;
        logic             last;
    } result_t;

endpackage

FILE: hdl/nrp_if.sv
// nrp_if: valid/ready channel interfaces for requests, results and configuration
// no dependencies beyond plain logic types
interface nrp_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [15:0] region_key;
    logic [31:0] timestamp;

    modport source (output valid, req_type, region_key, timestamp, input ready);
    modport sink   (input valid, req_type, region_key, timestamp, output ready);
endinterface

interface nrp_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [15:0] entry_key;
    logic [31:0] frame_time;
    logic [31:0] self_time;
    logic [31:0] call_count;
    logic [5:0]  depth;
    logic [14:0] min_pct;
    logic [14:0] avg_pct;
    logic [14:0] max_pct;
    logic        last;

    modport source (output valid, kind, status, entry_key, frame_time, self_time, call_count,
                    depth, min_pct, avg_pct, max_pct, last, input ready);
    modport sink   (input valid, kind, status, entry_key, frame_time, self_time, call_count,
                    depth, min_pct, avg_pct, max_pct, last, output ready);
endinterface

interface nrp_cfg_if;
    logic valid;
    logic ready;
    logic enabled;

    modport source (output valid, enabled, input ready);
    modport sink   (input valid, enabled, output ready);
endinterface

FILE: hdl/nrp_ram.sv
// nrp_ram: generic single-write, single-read memory with registered read data
// no dependencies
module nrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/nrp_div.sv
// nrp_div: radix-2 restoring divider, one quotient bit per cycle
// uses nrp_pkg; quotient must fit QW bits (upper dividend part below divisor)
module nrp_div #(
    parameter int DW = 17,
    parameter int QW = nrp_pkg::PCT_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DW+QW-1:0] num,
    input  logic [DW-1:0]    den,
    output logic             done,
    output logic [QW-1:0]    quo
);
    import nrp_pkg::*;

    localparam int CW = $clog2(QW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [QW-1:0]   low_reg, low_next;
    logic [QW-1:0]   q_reg, q_next;
    logic [DW-1:0]   den_reg, den_next;
    logic [DW:0]     trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        trial     = {rem_reg, low_reg[QW-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(QW);
            rem_next  = num[DW+QW-1:QW];
            low_next  = num[QW-1:0];
            den_next  = den;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            // bring down one dividend bit and try the subtract
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DW'(trial - {1'b0, den_reg});
                q_next   = {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW-1:0];
                q_next   = {q_reg[QW-2:0], 1'b0};
            end
            low_next = {low_reg[QW-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg) else $error("divider started while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("divider done held for two cycles");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg) else $error("divider did not begin after start");

endmodule

FILE: hdl/nested_region_profiler.sv
// nested_region_profiler: top level, request sequencer around the slot table and divider
// uses nrp_pkg, nrp_if interfaces, nrp_ram and nrp_div
//
// One request is taken at a time; ready is high only while the sequencer is idle. The
// slot table sits in a single-port-read RAM and is searched one slot per step; an open
// or a reset-one reads each valid slot up to the match, a close reads the closing
// region and, for a nested one, its parent, and a reset-all rewrites each valid slot.
// A report gives its header first and then one entry per valid slot: the shared
// radix-2 divider runs up to twice per entry (self share of the frame, then the
// running mean), and when the frame is wider than 48 bits it is first narrowed one
// bit per cycle. Valid and open flags are flip-flops cleared at reset, so there is
// no clearing pass. A finished result waits in an output register while the next
// request can be taken; further results stall until it is taken.
module nested_region_profiler #(
    parameter int SLOTS     = nrp_pkg::SLOTS_DEF,
    parameter int TIME_BITS = nrp_pkg::TIME_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    nrp_cfg_if.sink   cfg,
    nrp_req_if.sink   req,
    nrp_res_if.source res
);
    import nrp_pkg::*;

    localparam int SW   = $clog2(SLOTS);
    localparam int PW   = $clog2(SLOTS + 1);        // slot pointer, SLOTS means none
    localparam int FW   = (TIME_BITS < SCALE_W) ? TIME_BITS : SCALE_W;
    localparam int DIVW = (FW > 17) ? FW : 17;      // 17 covers report count plus one
    localparam int NUMW = DIVW + PCT_W;

    typedef struct packed {
        logic [15:0]          key;
        logic [PW-1:0]        parent;
        logic [PW-1:0]        depth;
        logic [31:0]          calls;
        logic [TIME_BITS-1:0] start;
        logic [TIME_BITS-1:0] total;
        logic [TIME_BITS-1:0] child;
        logic [PCT_W-1:0]     mn;
        logic [PCT_W-1:0]     mx;
        logic [PCT_W-1:0]     avg;
        logic [15:0]          reports;
    } rec_t;

    localparam int RW = $bits(rec_t);

    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
    endfunction

    function automatic result_t status_res(input logic [2:0] st);
        result_t r;
        r        = '0;
        r.kind   = KIND_STATUS;
        r.status = st;
        r.last   = 1'b1;
        return r;
    endfunction

    // control state
    state_t               state_reg, state_next;
    state_t               resume_reg, resume_next;
    logic [PW-1:0]        idx_reg, idx_next;
    logic [PW-1:0]        free_reg, free_next;
    logic                 hit_reg, hit_next;
    logic [SLOTS-1:0]     valid_reg, valid_next;
    logic [SLOTS-1:0]     open_reg, open_next;
    logic [PW-1:0]        innermost_reg, innermost_next;
    logic [PW-1:0]        depth_reg, depth_next;
    logic                 enabled_reg;
    logic                 res_valid_reg, res_valid_next;

    // datapath registers
    logic [TIME_BITS-1:0] root_begin_reg, root_begin_next;
    logic [TIME_BITS-1:0] root_end_reg, root_end_next;
    logic [TIME_BITS-1:0] el_reg, el_next;
    logic [TIME_BITS-1:0] self_reg, self_next;
    logic [TIME_BITS-1:0] sa_reg, sa_next;
    logic [TIME_BITS-1:0] fr_reg, fr_next;
    logic [TIME_BITS-1:0] frame_reg, frame_next;
    logic [PCT_W-1:0]     pct_reg, pct_next;
    logic [PCT_W-1:0]     avg_reg, avg_next;
    logic [30:0]          prod_reg, prod_next;
    result_t              pend_reg, pend_next;
    result_t              out_reg, out_next;
    logic [2:0]           rtype_reg;
    logic [15:0]          key_reg;
    logic [TIME_BITS-1:0] ts_reg;

    // table and divider hookup
    logic                 ram_we, ram_re;
    logic [SW-1:0]        ram_waddr, ram_raddr;
    logic [RW-1:0]        ram_rdata;
    rec_t                 rd_rec, wr_rec;
    logic                 div_start, div_done;
    logic [NUMW-1:0]      div_num, sa_ext;
    logic [DIVW-1:0]      div_den;
    logic [PCT_W-1:0]     div_quo;

    logic                 req_take, out_free, later_valid;
    logic [SW-1:0]        slot;

    assign req.ready = (state_reg == S_IDLE);
    assign req_take  = req.valid && req.ready;
    assign cfg.ready = 1'b1;
    assign out_free  = !res_valid_reg || res.ready;
    assign slot      = idx_reg[SW-1:0];
    assign rd_rec    = rec_t'(ram_rdata);
    assign sa_ext    = NUMW'(sa_reg);

    // any valid slot above the current one decides the last flag of an entry
    always_comb
    begin
        later_valid = 1'b0;
        for (int j = 0; j < SLOTS; j++)
        begin
            if (PW'(j) > idx_reg && valid_reg[j])
            begin
                later_valid = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        resume_next     = resume_reg;
        idx_next        = idx_reg;
        free_next       = free_reg;
        hit_next        = hit_reg;
        valid_next      = valid_reg;
        open_next       = open_reg;
        innermost_next  = innermost_reg;
        depth_next      = depth_reg;
        root_begin_next = root_begin_reg;
        root_end_next   = root_end_reg;
        el_next         = el_reg;
        self_next       = self_reg;
        sa_next         = sa_reg;
        fr_next         = fr_reg;
        frame_next      = frame_reg;
        pct_next        = pct_reg;
        avg_next        = avg_reg;
        prod_next       = prod_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        res_valid_next  = res_valid_reg && !res.ready;
        ram_we          = 1'b0;
        ram_waddr       = slot;
        ram_re          = 1'b0;
        ram_raddr       = slot;
        wr_rec          = rd_rec;
        div_start       = 1'b0;
        div_num         = '0;
        div_den         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    resume_next = S_IDLE;
                    idx_next    = '0;
                    free_next   = PW'(SLOTS);
                    hit_next    = 1'b0;
                    if (!enabled_reg)
                    begin
                        pend_next  = status_res(ST_DISABLED);
                        state_next = S_RESULT;
                    end
                    else if (req.req_type == REQ_OPEN || req.req_type == REQ_RESET_ONE)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (req.req_type == REQ_CLOSE)
                    begin
                        if (innermost_reg == PW'(SLOTS))
                        begin
                            pend_next  = status_res(ST_NONE_OPEN);
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            idx_next   = innermost_reg;
                            state_next = S_CL_RD;
                        end
                    end
                    else if (req.req_type == REQ_REPORT)
                    begin
                        // header first, then one entry per valid slot
                        frame_next           = root_end_reg - root_begin_reg;
                        pend_next            = '0;
                        pend_next.kind       = KIND_HEADER;
                        pend_next.frame_time = 32'(root_end_reg - root_begin_reg);
                        pend_next.last       = ~|valid_reg;
                        resume_next          = S_RP_SCAN;
                        state_next           = S_RESULT;
                    end
                    else if (req.req_type == REQ_RESET_ALL)
                    begin
                        state_next = S_ALL_SCAN;
                    end
                    else
                    begin
                        // undefined request codes change nothing and answer OK
                        pend_next  = status_res(ST_OK);
                        state_next = S_RESULT;
                    end
                end
            end

            S_SCAN:
            begin
                if (idx_reg == PW'(SLOTS))
                begin
                    if (rtype_reg == REQ_RESET_ONE)
                    begin
                        pend_next  = status_res(ST_NOT_FOUND);
                        state_next = S_RESULT;
                    end
                    else if (free_reg == PW'(SLOTS))
                    begin
                        pend_next  = status_res(ST_FULL);
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        idx_next   = free_reg;
                        state_next = S_OPEN_UPD;
                    end
                end
                else if (valid_reg[slot])
                begin
                    ram_re     = 1'b1;
                    state_next = S_SCAN_CHK;
                end
                else
                begin
                    if (free_reg == PW'(SLOTS))
                    begin
                        free_next = idx_reg;
                    end
                    idx_next = idx_reg + PW'(1);
                end
            end

            S_SCAN_CHK:
            begin
                if (rd_rec.key == key_reg)
                begin
                    if (rtype_reg == REQ_RESET_ONE)
                    begin
                        state_next = S_RST_UPD;
                    end
                    else if (open_reg[slot])
                    begin
                        pend_next  = status_res(ST_ALREADY);
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        hit_next   = 1'b1;
                        state_next = S_OPEN_UPD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + PW'(1);
                    state_next = S_SCAN;
                end
            end

            S_OPEN_UPD:
            begin
                if (hit_reg)
                begin
                    wr_rec.calls = (rd_rec.calls == '1) ? rd_rec.calls : rd_rec.calls + 32'd1;
                end
                else
                begin
                    // freshly claimed slot
                    wr_rec.key     = key_reg;
                    wr_rec.calls   = 32'd1;
                    wr_rec.total   = '0;
                    wr_rec.child   = '0;
                    wr_rec.mn      = '0;
                    wr_rec.mx      = '0;
                    wr_rec.avg     = '0;
                    wr_rec.reports = '0;
                end
                wr_rec.parent    = innermost_reg;
                wr_rec.depth     = depth_reg;
                wr_rec.start     = ts_reg;
                ram_we           = 1'b1;
                valid_next[slot] = 1'b1;
                open_next[slot]  = 1'b1;
                if (innermost_reg == PW'(SLOTS))
                begin
                    root_begin_next = ts_reg;
                end
                innermost_next = idx_reg;
                depth_next     = depth_reg + PW'(1);
                pend_next      = status_res(ST_OK);
                state_next     = S_RESULT;
            end

            S_RST_UPD:
            begin
                wr_rec.reports = '0;
                wr_rec.mn      = '0;
                wr_rec.mx      = '0;
                ram_we         = 1'b1;
                pend_next      = status_res(ST_OK);
                state_next     = S_RESULT;
            end

            S_CL_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_CL_SELF;
            end

            S_CL_SELF:
            begin
                // charge the elapsed time to the closing region
                el_next         = ts_reg - rd_rec.start;
                wr_rec.total    = sat_add(rd_rec.total, ts_reg - rd_rec.start);
                ram_we          = 1'b1;
                open_next[slot] = 1'b0;
                innermost_next  = rd_rec.parent;
                idx_next        = rd_rec.parent;
                if (depth_reg != '0)
                begin
                    depth_next = depth_reg - PW'(1);
                end
                if (rd_rec.parent == PW'(SLOTS))
                begin
                    root_end_next = ts_reg;
                    pend_next     = status_res(ST_OK);
                    state_next    = S_RESULT;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = rd_rec.parent[SW-1:0];
                    state_next = S_CL_PAR;
                end
            end

            S_CL_PAR:
            begin
                // and to the parent's child time
                wr_rec.child = sat_add(rd_rec.child, el_reg);
                ram_we       = 1'b1;
                pend_next    = status_res(ST_OK);
                state_next   = S_RESULT;
            end

            S_ALL_SCAN:
            begin
                if (idx_reg == PW'(SLOTS))
                begin
                    pend_next  = status_res(ST_OK);
                    state_next = S_RESULT;
                end
                else if (valid_reg[slot])
                begin
                    ram_re     = 1'b1;
                    state_next = S_ALL_UPD;
                end
                else
                begin
                    idx_next = idx_reg + PW'(1);
                end
            end

            S_ALL_UPD:
            begin
                wr_rec.reports = '0;
                wr_rec.mn      = '0;
                wr_rec.mx      = '0;
                ram_we         = 1'b1;
                idx_next       = idx_reg + PW'(1);
                state_next     = S_ALL_SCAN;
            end

            S_RP_SCAN:
            begin
                if (idx_reg == PW'(SLOTS))
                begin
                    state_next = S_IDLE;
                end
                else if (valid_reg[slot])
                begin
                    ram_re     = 1'b1;
                    state_next = S_RP_SELF;
                end
                else
                begin
                    idx_next = idx_reg + PW'(1);
                end
            end

            S_RP_SELF:
            begin
                self_next  = (rd_rec.total > rd_rec.child) ? rd_rec.total - rd_rec.child : '0;
                sa_next    = (rd_rec.total > rd_rec.child) ? rd_rec.total - rd_rec.child : '0;
                fr_next    = frame_reg;
                state_next = S_RP_SCALE;
            end

            S_RP_SCALE:
            begin
                if ((fr_reg >> FW) != '0)
                begin
                    // narrow the frame to the divider width, one bit a cycle
                    fr_next = fr_reg >> 1;
                    sa_next = sa_reg >> 1;
                end
                else if (fr_reg == '0)
                begin
                    pct_next   = '0;
                    state_next = S_RP_MUL;
                end
                else if (sa_reg >= fr_reg)
                begin
                    pct_next   = FULL_PCT;
                    state_next = S_RP_MUL;
                end
                else
                begin
                    // self * 25600 as shifted adds: (64 + 32 + 4) << 8
                    div_num    = ((sa_ext << 6) + (sa_ext << 5) + (sa_ext << 2)) << 8;
                    div_den    = DIVW'(fr_reg);
                    div_start  = 1'b1;
                    state_next = S_RP_DIV1;
                end
            end

            S_RP_DIV1:
            begin
                if (div_done)
                begin
                    pct_next   = div_quo;
                    state_next = S_RP_MUL;
                end
            end

            S_RP_MUL:
            begin
                prod_next  = {16'd0, rd_rec.avg} * {15'd0, rd_rec.reports};
                state_next = S_RP_AVG;
            end

            S_RP_AVG:
            begin
                div_num    = NUMW'(prod_reg) + NUMW'(pct_reg);
                div_den    = DIVW'({1'b0, rd_rec.reports} + 17'd1);
                div_start  = 1'b1;
                state_next = S_RP_DIV2;
            end

            S_RP_DIV2:
            begin
                if (div_done)
                begin
                    avg_next   = div_quo;
                    state_next = S_RP_UPD;
                end
            end

            S_RP_UPD:
            begin
                if (rd_rec.reports == '0)
                begin
                    wr_rec.mn = pct_reg;
                    wr_rec.mx = pct_reg;
                end
                else
                begin
                    wr_rec.mn = (pct_reg < rd_rec.mn) ? pct_reg : rd_rec.mn;
                    wr_rec.mx = (pct_reg > rd_rec.mx) ? pct_reg : rd_rec.mx;
                end
                wr_rec.avg     = avg_reg;
                wr_rec.reports = (rd_rec.reports == '1) ? rd_rec.reports
                                                        : rd_rec.reports + 16'd1;
                wr_rec.calls   = '0;
                wr_rec.total   = '0;
                wr_rec.child   = '0;
                ram_we         = 1'b1;

                pend_next            = '0;
                pend_next.kind       = KIND_ENTRY;
                pend_next.entry_key  = rd_rec.key;
                pend_next.self_time  = 32'(self_reg);
                pend_next.call_count = rd_rec.calls;
                pend_next.depth      = 6'(rd_rec.depth);
                pend_next.min_pct    = wr_rec.mn;
                pend_next.avg_pct    = avg_reg;
                pend_next.max_pct    = wr_rec.mx;
                pend_next.last       = !later_valid;

                idx_next    = idx_reg + PW'(1);
                resume_next = S_RP_SCAN;
                state_next  = S_RESULT;
            end

            S_RESULT:
            begin
                // hand the transaction to the output register once it is free
                if (out_free)
                begin
                    out_next       = pend_reg;
                    res_valid_next = 1'b1;
                    state_next     = resume_reg;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            resume_reg     <= S_IDLE;
            idx_reg        <= '0;
            free_reg       <= '0;
            hit_reg        <= 1'b0;
            valid_reg      <= '0;
            open_reg       <= '0;
            innermost_reg  <= PW'(SLOTS);
            depth_reg      <= '0;
            root_begin_reg <= '0;
            root_end_reg   <= '0;
            enabled_reg    <= 1'b1;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            resume_reg     <= resume_next;
            idx_reg        <= idx_next;
            free_reg       <= free_next;
            hit_reg        <= hit_next;
            valid_reg      <= valid_next;
            open_reg       <= open_next;
            innermost_reg  <= innermost_next;
            depth_reg      <= depth_next;
            root_begin_reg <= root_begin_next;
            root_end_reg   <= root_end_next;
            res_valid_reg  <= res_valid_next;
            if (cfg.valid)
            begin
                enabled_reg <= cfg.enabled;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        el_reg    <= el_next;
        self_reg  <= self_next;
        sa_reg    <= sa_next;
        fr_reg    <= fr_next;
        frame_reg <= frame_next;
        pct_reg   <= pct_next;
        avg_reg   <= avg_next;
        prod_reg  <= prod_next;
        pend_reg  <= pend_next;
        out_reg   <= out_next;
        if (req_take)
        begin
            rtype_reg <= req.req_type;
            key_reg   <= req.region_key;
            ts_reg    <= TIME_BITS'(req.timestamp);
        end
    end

    nrp_ram #(
        .WIDTH (RW),
        .DEPTH (SLOTS)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (RW'(wr_rec)),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    nrp_div #(
        .DW (DIVW),
        .QW (PCT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign res.valid      = res_valid_reg;
    assign res.kind       = out_reg.kind;
    assign res.status     = out_reg.status;
    assign res.entry_key  = out_reg.entry_key;
    assign res.frame_time = out_reg.frame_time;
    assign res.self_time  = out_reg.self_time;
    assign res.call_count = out_reg.call_count;
    assign res.depth      = out_reg.depth;
    assign res.min_pct    = out_reg.min_pct;
    assign res.avg_pct    = out_reg.avg_pct;
    assign res.max_pct    = out_reg.max_pct;
    assign res.last       = out_reg.last;

    a_open_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (open_reg & ~valid_reg) == '0) else $error("open flag on an unclaimed slot");
    a_stack_depth: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(open_reg) == int'(depth_reg)) else $error("open depth out of step");
    a_none_open: assert property (@(posedge clk) disable iff (!rst_n)
        (innermost_reg == PW'(SLOTS)) == (depth_reg == '0))
        else $error("innermost pointer disagrees with open depth");

endmodule
